FILE: rtl/owo_pkg.sv
// shared constants, control struct and arctangent table for the omni odometry block
// no dependencies; imported by owo_cordic, owo_mac and three_wheel_omni_odometry
package owo_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int COEF_WIDTH     = 18;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_CNT_W = $clog2(CORDIC_STEPS);
  localparam int CORDIC_W     = 34;

  localparam int MAC_A_W = 34;
  localparam int MAC_B_W = 25;
  localparam int MAC_P_W = MAC_A_W + MAC_B_W;
  localparam int ACC_W   = 64;
  // split point of the turn * dt product before it is scaled to angle units
  localparam int TK_SPLIT = 24;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [MAC_A_W-1:0]  INV_TWO_PI_Q24  = 34'sd2670177;

  typedef struct packed {
    logic init;   // load accumulator with init value
    logic issue;  // operands valid this cycle
    logic neg;    // subtract this product
    logic shl;    // product weighted by 2^TK_SPLIT
  } mac_ctl_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [CORDIC_W-1:0] atan_turn(
    input logic [CORDIC_CNT_W-1:0] i
  );
    logic signed [CORDIC_W-1:0] v;
    case (i)
      4'd0:    v = 34'sd536870912;
      4'd1:    v = 34'sd316933406;
      4'd2:    v = 34'sd167458907;
      4'd3:    v = 34'sd85004756;
      4'd4:    v = 34'sd42667331;
      4'd5:    v = 34'sd21354465;
      4'd6:    v = 34'sd10679838;
      4'd7:    v = 34'sd5340245;
      4'd8:    v = 34'sd2670163;
      4'd9:    v = 34'sd1335087;
      4'd10:   v = 34'sd667544;
      4'd11:   v = 34'sd333772;
      4'd12:   v = 34'sd166886;
      4'd13:   v = 34'sd83443;
      4'd14:   v = 34'sd41722;
      default: v = 34'sd20861;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/owo_cordic.sv
// iterative cordic: sine and cosine in q.30 of a 32-bit binary angle, one step a cycle
// depends on owo_pkg
module owo_cordic import owo_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [31:0]                ang,
  output logic                       done,
  output logic signed [CORDIC_W-1:0] sin_out,
  output logic signed [CORDIC_W-1:0] cos_out
);

  localparam logic signed [CORDIC_W-1:0] QUARTER = 34'sd1073741824;
  localparam logic signed [CORDIC_W-1:0] HALF    = 34'sd2147483648;
  localparam logic [CORDIC_CNT_W-1:0]    LAST    = CORDIC_CNT_W'(CORDIC_STEPS - 1);

  logic signed [CORDIC_W-1:0] x_r, y_r, z_r;
  logic                       flip_r;
  logic [CORDIC_CNT_W-1:0]    cnt_r;
  logic                       busy_r, done_r;

  logic signed [CORDIC_W-1:0] z_in, z0, dx, dy, at;
  logic                       flip0;

  // fold into the right half plane
  always_comb begin
    z_in  = {{(CORDIC_W-32){ang[31]}}, ang};
    z0    = z_in;
    flip0 = 1'b0;
    if (z_in > QUARTER) begin
      z0    = z_in - HALF;
      flip0 = 1'b1;
    end else if (z_in < -QUARTER) begin
      z0    = z_in + HALF;
      flip0 = 1'b1;
    end
  end

  assign dx = y_r >>> cnt_r;
  assign dy = x_r >>> cnt_r;
  assign at = atan_turn(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      x_r    <= CORDIC_GAIN_Q30;
      y_r    <= '0;
      z_r    <= z0;
      flip_r <= flip0;
      cnt_r  <= '0;
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      if (!z_r[CORDIC_W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
      if (cnt_r == LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign done    = done_r;
  assign sin_out = flip_r ? -y_r : y_r;
  assign cos_out = flip_r ? -x_r : x_r;

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && !done_r)
    else $error("cordic did not start");

  a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start && cnt_r == LAST) |=> done_r && !busy_r)
    else $error("cordic did not finish after last step");

endmodule

FILE: rtl/owo_mac.sv
// shared signed multiply-accumulate unit: registered product, then accumulate
// depends on owo_pkg
module owo_mac import owo_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mac_ctl_t                  ctl,
  input  logic signed [MAC_A_W-1:0] op_a,
  input  logic signed [MAC_B_W-1:0] op_b,
  input  logic signed [ACC_W-1:0]   init_val,
  output logic signed [ACC_W-1:0]   acc
);

  logic signed [MAC_P_W-1:0] prod_r;
  logic                      vld_r, neg_r, shl_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   prod_ext, addend;

  assign prod_ext = {{(ACC_W-MAC_P_W){prod_r[MAC_P_W-1]}}, prod_r};
  assign addend   = shl_r ? (prod_ext <<< TK_SPLIT) : prod_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctl.issue;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    neg_r  <= ctl.neg;
    shl_r  <= ctl.shl;
    if (ctl.init) begin
      acc_r <= init_val;
    end else if (vld_r) begin
      acc_r <= neg_r ? (acc_r - addend) : (acc_r + addend);
    end
  end

  assign acc = acc_r;

endmodule

FILE: rtl/three_wheel_omni_odometry.sv
// three-wheel omni odometry top level: config registers, pose state, sequencer
// depends on owo_pkg, owo_cordic and owo_mac
//
// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    in_tdata: wheel_a, wheel_b, wheel_c, step_time
//                                      in_tuser: cmd (1 clears pose)
// out_     out  out_tvalid/out_tready  out_tdata: pose_x, pose_y, pose_heading,
//                                      frame_vel_x, frame_vel_y, turn_rate
// cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data (coefficient rows 0..2)
//
// an update beat passes 18 products one at a time through the shared multiply-accumulate
// unit, each group of products followed by a drain and a capture slot; the 16-step
// cordic runs alongside the wheel products, and the sequencer waits for its result
// before the rotation. a clear beat goes through the output state into the output
// register.
// in_tready is high only in idle; a result waits in the output register, and a
// following beat is taken meanwhile but holds in its last state until that register
// frees up. reset is synchronous: pose, heading and coefficients clear to zero.
module three_wheel_omni_odometry import owo_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // input beats
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [87:0]  in_tdata,   // wheel_a_speed, wheel_b_speed, wheel_c_speed, step_time
  input  logic         in_tuser,   // cmd
  // result beats
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [151:0] out_tdata,  // pose_x, pose_y, pose_heading, frame_vel_x,
                                   // frame_vel_y, turn_rate
  // coefficient writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [53:0]  cfg_data
);

  // angle integration: product scaled to 2^56 per turn, keep ANGLE_BITS bits
  localparam int HSHIFT = 56 - ANGLE_BITS;
  localparam int TDT_W  = 41;

  localparam logic [1:0] REG_COEF_ROW_0 = 2'd0;
  localparam logic [1:0] REG_COEF_ROW_1 = 2'd1;
  localparam logic [1:0] REG_COEF_ROW_2 = 2'd2;

  localparam logic signed [ACC_W-1:0] RND_COEF = 64'sd1 <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] RND_ROT  = 64'sd1 <<< 29;
  localparam logic signed [ACC_W-1:0] RND_POS  = 64'sd1 <<< 15;

  typedef enum logic [2:0] {
    S_IDLE, S_ROBOT, S_WAIT, S_ROT, S_TDT, S_TK, S_POS, S_OUT
  } state_t;

  function automatic logic signed [23:0] sat24(input logic signed [ACC_W-1:0] v);
    logic signed [23:0] r;
    if (v > 64'sd8388607) r = 24'sh7FFFFF;
    else if (v < -64'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // configuration and pose state
  logic [53:0]            coef_r [3];
  logic signed [31:0]     pos_x_r, pos_y_r;
  logic [ANGLE_BITS-1:0]  heading_r;

  // per-update working registers
  logic signed [23:0]     wheel_r [3];
  logic [15:0]            dt_r;
  logic signed [23:0]     robot_r [3];
  logic signed [23:0]     vx_r, vy_r;
  logic signed [TDT_W-1:0] t_r;

  // sequencer
  state_t                 state_r;
  logic [2:0]             slot_r;
  logic [1:0]             row_r;
  logic                   out_tvalid_r;
  logic [151:0]           out_tdata_r;

  // shared unit hookup
  mac_ctl_t                  mac_ctl;
  logic signed [MAC_A_W-1:0] mac_a;
  logic signed [MAC_B_W-1:0] mac_b;
  logic signed [ACC_W-1:0]   mac_init;
  logic signed [ACC_W-1:0]   mac_acc;
  logic [2:0]                grp_n;
  logic                      slot_end;

  logic [31:0]               ang32;
  logic                      cor_done;
  logic signed [CORDIC_W-1:0] cor_sin, cor_cos;
  logic                      in_beat;
  logic signed [COEF_WIDTH-1:0] coef_sel;
  logic signed [23:0]        wheel_sel;

  assign in_beat   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign ang32     = {heading_r, {(32-ANGLE_BITS){1'b0}}};

  // operand selection for the current product group
  always_comb begin
    case (slot_r[1:0])
      2'd0:    coef_sel = coef_r[row_r][COEF_WIDTH-1:0];
      2'd1:    coef_sel = coef_r[row_r][2*COEF_WIDTH-1:COEF_WIDTH];
      default: coef_sel = coef_r[row_r][3*COEF_WIDTH-1:2*COEF_WIDTH];
    endcase
    case (slot_r[1:0])
      2'd0:    wheel_sel = wheel_r[0];
      2'd1:    wheel_sel = wheel_r[1];
      default: wheel_sel = wheel_r[2];
    endcase
  end

  always_comb begin
    grp_n    = 3'd0;
    mac_a    = '0;
    mac_b    = '0;
    mac_init = '0;
    case (state_r)
      S_ROBOT: begin
        // one row of the inverse kinematics matrix
        grp_n    = 3'd3;
        mac_a    = {{(MAC_A_W-COEF_WIDTH){coef_sel[COEF_WIDTH-1]}}, coef_sel};
        mac_b    = {wheel_sel[23], wheel_sel};
        mac_init = RND_COEF;
      end
      S_ROT: begin
        // vx = cos*fwd - sin*side, vy = sin*fwd + cos*side
        grp_n    = 3'd2;
        mac_a    = (row_r[0] == slot_r[0]) ? cor_cos : cor_sin;
        mac_b    = slot_r[0] ? {robot_r[1][23], robot_r[1]} : {robot_r[0][23], robot_r[0]};
        mac_init = RND_ROT;
      end
      S_TDT: begin
        grp_n    = 3'd1;
        mac_a    = {{(MAC_A_W-16){1'b0}}, dt_r};
        mac_b    = {robot_r[2][23], robot_r[2]};
        mac_init = '0;
      end
      S_TK: begin
        // turn*dt scaled to angle units, in a low and a high part
        grp_n    = 3'd2;
        mac_a    = INV_TWO_PI_Q24;
        mac_b    = slot_r[0] ?
                   {{(MAC_B_W-(TDT_W-TK_SPLIT)){t_r[TDT_W-1]}}, t_r[TDT_W-1:TK_SPLIT]} :
                   {1'b0, t_r[TK_SPLIT-1:0]};
        mac_init = $signed(({{(ACC_W-ANGLE_BITS){1'b0}}, heading_r} << HSHIFT)
                   + (64'd1 << (HSHIFT - 1)));
      end
      S_POS: begin
        // old position folded in at weight 2^16 with the rounding offset
        grp_n    = 3'd1;
        mac_a    = {{(MAC_A_W-16){1'b0}}, dt_r};
        mac_b    = row_r[0] ? {vy_r[23], vy_r} : {vx_r[23], vx_r};
        mac_init = row_r[0] ?
                   (({{32{pos_y_r[31]}}, pos_y_r} <<< 16) + RND_POS) :
                   (({{32{pos_x_r[31]}}, pos_x_r} <<< 16) + RND_POS);
      end
      default: ;
    endcase
    mac_ctl.issue = (slot_r < grp_n);
    mac_ctl.init  = (grp_n != 3'd0) && (slot_r == 3'd0);
    mac_ctl.neg   = (state_r == S_ROT) && (row_r == 2'd0) && (slot_r == 3'd1);
    mac_ctl.shl   = (state_r == S_TK) && (slot_r == 3'd1);
  end

  // products issue, then a drain slot, then the capture slot
  assign slot_end = (slot_r == grp_n + 3'd1);

  owo_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mac_ctl),
    .op_a     (mac_a),
    .op_b     (mac_b),
    .init_val (mac_init),
    .acc      (mac_acc)
  );

  owo_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_beat && !in_tuser),
    .ang     (ang32),
    .done    (cor_done),
    .sin_out (cor_sin),
    .cos_out (cor_cos)
  );

  // coefficient registers, an index past the last row is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0] <= '0;
      coef_r[1] <= '0;
      coef_r[2] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COEF_ROW_0: coef_r[0] <= cfg_data;
        REG_COEF_ROW_1: coef_r[1] <= cfg_data;
        REG_COEF_ROW_2: coef_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, pose state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_r       <= '0;
      row_r        <= '0;
      out_tvalid_r <= 1'b0;
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      heading_r    <= '0;
    end else begin
      // a taken result frees the register unless a new one loads this cycle
      if (out_tready && (state_r != S_OUT)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            wheel_r[0] <= in_tdata[23:0];
            wheel_r[1] <= in_tdata[47:24];
            wheel_r[2] <= in_tdata[71:48];
            dt_r       <= in_tdata[87:72];
            slot_r     <= '0;
            row_r      <= '0;
            if (in_tuser) begin
              // clear: pose to zero, velocities reported as zero
              pos_x_r    <= '0;
              pos_y_r    <= '0;
              heading_r  <= '0;
              vx_r       <= '0;
              vy_r       <= '0;
              robot_r[2] <= '0;
              state_r    <= S_OUT;
            end else begin
              state_r <= S_ROBOT;
            end
          end
        end
        S_ROBOT: begin
          if (slot_end) begin
            robot_r[row_r] <= sat24(mac_acc >>> COEF_FRAC_BITS);
            slot_r         <= '0;
            if (row_r == 2'd2) begin
              row_r   <= '0;
              state_r <= S_WAIT;
            end else begin
              row_r <= row_r + 2'd1;
            end
          end else begin
            slot_r <= slot_r + 3'd1;
          end
        end
        S_WAIT: begin
          if (cor_done) begin
            state_r <= S_ROT;
          end
        end
        S_ROT: begin
          if (slot_end) begin
            slot_r <= '0;
            if (row_r[0]) begin
              vy_r    <= sat24(mac_acc >>> 30);
              row_r   <= '0;
              state_r <= S_TDT;
            end else begin
              vx_r  <= sat24(mac_acc >>> 30);
              row_r <= 2'd1;
            end
          end else begin
            slot_r <= slot_r + 3'd1;
          end
        end
        S_TDT: begin
          if (slot_end) begin
            t_r     <= mac_acc[TDT_W-1:0];
            slot_r  <= '0;
            state_r <= S_TK;
          end else begin
            slot_r <= slot_r + 3'd1;
          end
        end
        S_TK: begin
          if (slot_end) begin
            // heading wraps modulo a full turn
            heading_r <= mac_acc[HSHIFT +: ANGLE_BITS];
            slot_r    <= '0;
            state_r   <= S_POS;
          end else begin
            slot_r <= slot_r + 3'd1;
          end
        end
        S_POS: begin
          if (slot_end) begin
            slot_r <= '0;
            if (row_r[0]) begin
              pos_y_r <= sat32(mac_acc >>> 16);
              row_r   <= '0;
              state_r <= S_OUT;
            end else begin
              pos_x_r <= sat32(mac_acc >>> 16);
              row_r   <= 2'd1;
            end
          end else begin
            slot_r <= slot_r + 3'd1;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {robot_r[2], vy_r, vx_r, ang32[31:16], pos_y_r, pos_x_r};
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_rot_after_cordic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT) |-> cor_done)
    else $error("rotation started before sine and cosine were ready");

  a_mac_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_WAIT || state_r == S_OUT)
      |-> !mac_ctl.issue && !mac_ctl.init)
    else $error("multiply-accumulate unit used outside a product group");

  a_heading_update: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(heading_r))
      |-> ($past(state_r) == S_TK) || $past(in_tvalid && in_tready))
    else $error("heading changed outside integration or clear");

endmodule
